FILE: rtl/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
`default_nettype none
package bdpc_pkg;

  localparam int TimeW  = 32;
  localparam int CfgW   = 16;
  localparam int EventW = 2;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  // press_event codes
  localparam logic [EventW-1:0] EVENT_NONE  = 2'd0;
  localparam logic [EventW-1:0] EVENT_SHORT = 2'd1;
  localparam logic [EventW-1:0] EVENT_LONG  = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_IDLE_LEVEL = 2'd2;

  localparam logic [CfgW-1:0] DEBOUNCE_RST   = 16'd35;
  localparam logic [CfgW-1:0] LONG_PRESS_RST = 16'd1100;
  localparam logic            IDLE_LEVEL_RST = 1'b0;

  typedef struct packed {
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] long_press_time;
    logic            idle_level;
  } cfg_t;

  // idle level rewrite: debounce state set to the new level with no press; time stamps kept
  typedef struct packed {
    logic wr;
    logic level;
  } idle_load_t;

endpackage
`default_nettype wire

FILE: rtl/bdpc_cfg_regs.sv
// APB-style configuration registers of the press classifier.
`default_nettype none
module bdpc_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bdpc_pkg::AddrW-1:0] paddr,
  input  wire logic [bdpc_pkg::DataW-1:0] pwdata,
  output logic      [bdpc_pkg::DataW-1:0] prdata,
  output logic                            pready,
  output bdpc_pkg::cfg_t                  cfg,
  output bdpc_pkg::idle_load_t            idle_load
);
  import bdpc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time   <= DEBOUNCE_RST;
      cfg.long_press_time <= LONG_PRESS_RST;
      cfg.idle_level      <= IDLE_LEVEL_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEBOUNCE:   cfg.debounce_time   <= pwdata[CfgW-1:0];
        REG_LONG_PRESS: cfg.long_press_time <= pwdata[CfgW-1:0];
        REG_IDLE_LEVEL: cfg.idle_level      <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign idle_load.wr    = wr_en && (reg_idx == REG_IDLE_LEVEL);
  assign idle_load.level = pwdata[0];

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_DEBOUNCE:   prdata[CfgW-1:0] = cfg.debounce_time;
      REG_LONG_PRESS: prdata[CfgW-1:0] = cfg.long_press_time;
      REG_IDLE_LEVEL: prdata[0]        = cfg.idle_level;
      default:        prdata           = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/bdpc_classifier.sv
// Debounce state and press classification for one sample.
`default_nettype none
module bdpc_classifier (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic                        raw,
  input  wire logic [bdpc_pkg::TimeW-1:0]  now,
  input  bdpc_pkg::cfg_t                   cfg,
  input  bdpc_pkg::idle_load_t             idle_load,
  output logic      [bdpc_pkg::EventW-1:0] event_code
);
  import bdpc_pkg::*;

  logic             previous_raw, previous_raw_next;
  logic             stable_level, stable_level_next;
  logic             is_pressed, is_pressed_next;
  logic [TimeW-1:0] change_stamp, change_stamp_next;
  logic [TimeW-1:0] press_stamp, press_stamp_next;

  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] held;
  logic             settled;
  logic             down;

  always_comb begin
    previous_raw_next = previous_raw;
    stable_level_next = stable_level;
    is_pressed_next   = is_pressed;
    change_stamp_next = change_stamp;
    press_stamp_next  = press_stamp;
    event_code        = EVENT_NONE;

    // a raw edge restarts the timer, so elapsed time is then zero
    if (raw != previous_raw) begin
      previous_raw_next = raw;
      change_stamp_next = now;
    end
    since_change = now - change_stamp_next;
    held         = now - press_stamp;
    settled      = (since_change >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_time})
                   && (raw != stable_level);
    down         = (raw != cfg.idle_level);

    if (settled) begin
      stable_level_next = raw;
      if (down && !is_pressed) begin
        is_pressed_next  = 1'b1;
        press_stamp_next = now;
      end else if (!down && is_pressed) begin
        is_pressed_next = 1'b0;
        event_code = (held >= {{(TimeW-CfgW){1'b0}}, cfg.long_press_time})
                     ? EVENT_LONG : EVENT_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw <= IDLE_LEVEL_RST;
      stable_level <= IDLE_LEVEL_RST;
      is_pressed   <= 1'b0;
      change_stamp <= '0;
      press_stamp  <= '0;
    end else if (idle_load.wr) begin
      previous_raw <= idle_load.level;
      stable_level <= idle_load.level;
      is_pressed   <= 1'b0;
    end else if (fire) begin
      previous_raw <= previous_raw_next;
      stable_level <= stable_level_next;
      is_pressed   <= is_pressed_next;
      change_stamp <= change_stamp_next;
      press_stamp  <= press_stamp_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/button_debounce_press_classifier_core.sv
// Top level of the button debounce and short/long press classifier.
// Path: input register, then result register. Throughput when not stalled:
//   one sample per cycle; the input register feeds the classifier,
//   whose state is updated at the same edge that loads the result register.
// Reset (rst, synchronous): pipeline emptied, registers to 35 ms / 1100 ms /
//   idle low, debounce state to idle with no press and zero time stamps.
`default_nettype none
module button_debounce_press_classifier_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // sample channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        raw_level,
  input  wire logic [bdpc_pkg::TimeW-1:0]  now_time,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [bdpc_pkg::EventW-1:0] press_event,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bdpc_pkg::AddrW-1:0]  paddr,
  input  wire logic [bdpc_pkg::DataW-1:0]  pwdata,
  output logic      [bdpc_pkg::DataW-1:0]  prdata,
  output logic                             pready
);
  import bdpc_pkg::*;

  cfg_t       cfg;
  idle_load_t idle_load;

  // input register
  logic             s1_valid;
  logic             s1_raw;
  logic [TimeW-1:0] s1_now;

  logic              advance;     // s1 item moves into the result register
  logic              in_fire;
  logic [EventW-1:0] event_code;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_raw <= raw_level;
      s1_now <= now_time;
    end
  end

  bdpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .idle_load (idle_load)
  );

  bdpc_classifier u_cls (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .raw        (s1_raw),
    .now        (s1_now),
    .cfg        (cfg),
    .idle_load  (idle_load),
    .event_code (event_code)
  );

  // result register: holds while stalled, takes the next item otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      press_event <= event_code;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bdpc_checker.sv
// Port-level checks of the press classifier, bound to the top level.
`default_nettype none
module bdpc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [bdpc_pkg::EventW-1:0] press_event
);
  import bdpc_pkg::*;

  // never an undefined event code
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (press_event == EVENT_NONE || press_event == EVENT_SHORT ||
                   press_event == EVENT_LONG))
    else $error("press_event carries an undefined code");

  // a release needs a press in between, so two releases never come in a row
  a_no_double_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && press_event != EVENT_NONE)
      ##1 (out_valid && !out_stall) |-> press_event == EVENT_NONE)
    else $error("two release items in succession");

  // an accepted item reaches the output register when the output is not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach the output");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(press_event)))
    else $error("stalled result changed");

endmodule

bind button_debounce_press_classifier_core bdpc_checker u_bdpc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .press_event (press_event)
);
`default_nettype wire
